/* design/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants of the collinear triple point set.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int ROW_W  = 7;
  localparam int SH_W   = 3;
  localparam int CELL_W = 2 * ROW_W;
  localparam int KEY_W  = 2 * ROW_W + 1;
  localparam int LINES  = 2 ** ROW_W;
  localparam int CELLS  = 2 ** CELL_W;
  localparam int KEYS   = 2 ** KEY_W;
  localparam int FILL_W = 2;
  localparam int SIDE_W = 8;
  localparam int THRU_W = 15;
  localparam int TOT_W  = 22;
  localparam int PCNT_W = 9;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd128;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 8'd2;
  localparam logic [FILL_W-1:0] LINE_CAP   = 2'd2;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [THRU_W-1:0]   triples_through;
    logic [TOT_W-1:0]    total_triples;
    logic [PCNT_W-1:0]   point_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_CLEAR,
    S_FIX_RD,
    S_FIX_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic init_step;
    logic latch;
    logic look;
    logic decide;
    logic scan;
    logic clear;
    logic fix_rd;
    logic fix_wr;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic refused;
    logic scan_done;
    logic drain_done;
    logic clear_done;
  } sts_t;

endpackage

/* design/ctp_dir_pipe.sv */
// ----------------------------------------------------------------------------
// ctp_dir_pipe
// Pipelined direction unit: takes a held cell and the centre cell, gives the
// primitive, sign-normalised direction between them as a key, one per cycle.
// ----------------------------------------------------------------------------
module ctp_dir_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_v,
  input  logic [ctp_pkg::CELL_W-1:0] q,
  input  logic [ctp_pkg::CELL_W-1:0] c,
  output logic                       out_v,
  output logic [ctp_pkg::KEY_W-1:0]  key,
  output logic                       busy
);
  import ctp_pkg::*;

  localparam int NGCD = 2 * ROW_W;

  typedef struct packed {
    logic [ROW_W-1:0] ua;
    logic [ROW_W-1:0] ub;
    logic             bneg;
    logic [SH_W-1:0]  k;
    logic [ROW_W-1:0] u;
    logic [ROW_W-1:0] v;
  } gcd_t;

  typedef struct packed {
    logic [ROW_W-1:0] ua;
    logic [ROW_W-1:0] ub;
    logic             bneg;
    logic [ROW_W-1:0] d;
    logic [ROW_W-1:0] ra;
    logic [ROW_W-1:0] rb;
    logic [ROW_W-1:0] qa;
    logic [ROW_W-1:0] qb;
  } div_t;

  function automatic logic [SH_W-1:0] ctz(input logic [ROW_W-1:0] x);
    logic [SH_W-1:0] n;
    n = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (x[i]) n = SH_W'(i);
    end
    return n;
  endfunction

  // One binary gcd step: strip twos from v, then replace the larger by the gap
  function automatic gcd_t gcd_step(input gcd_t s);
    gcd_t             r;
    logic [ROW_W-1:0] w;
    r = s;
    w = s.v >> ctz(s.v);
    if (s.v != '0) begin
      if (s.u > w) begin
        r.u = w;
        r.v = s.u - w;
      end else begin
        r.v = w - s.u;
      end
    end
    return r;
  endfunction

  // One restoring division bit for both components
  function automatic div_t div_step(input div_t s, input int idx);
    div_t           r;
    logic [ROW_W:0] ta;
    logic [ROW_W:0] tb;
    r  = s;
    ta = {s.ra, s.ua[idx]};
    tb = {s.rb, s.ub[idx]};
    if (ta >= {1'b0, s.d}) begin
      ta        = ta - {1'b0, s.d};
      r.qa[idx] = 1'b1;
    end
    if (tb >= {1'b0, s.d}) begin
      tb        = tb - {1'b0, s.d};
      r.qb[idx] = 1'b1;
    end
    r.ra = ta[ROW_W-1:0];
    r.rb = tb[ROW_W-1:0];
    return r;
  endfunction

  logic signed [ROW_W:0] dr, dc, nr, nc, anc;
  logic                  same, neg;
  logic                  av;
  logic [ROW_W-1:0]      a_ua, a_ub;
  logic                  a_bneg;
  logic [SH_W-1:0]       k0;
  logic [ROW_W-1:0]      x0, y0;
  gcd_t                  ginit;
  div_t                  dinit;
  gcd_t                  gs [NGCD+1];
  logic [NGCD:0]         gv;
  div_t                  ds [ROW_W];
  logic [ROW_W-1:0]      dv;
  logic [ROW_W:0]        bq, b8;

  always_comb begin
    same = (q == c);
    dr   = signed'({1'b0, q[CELL_W-1:ROW_W]}) - signed'({1'b0, c[CELL_W-1:ROW_W]});
    dc   = signed'({1'b0, q[ROW_W-1:0]}) - signed'({1'b0, c[ROW_W-1:0]});
    neg  = (dr < 0) || ((dr == 0) && (dc < 0));
    nr   = neg ? -dr : dr;
    nc   = neg ? -dc : dc;
    anc  = (nc < 0) ? -nc : nc;
  end

  always_comb begin
    k0         = ctz(a_ua | a_ub);
    x0         = a_ua >> k0;
    y0         = a_ub >> k0;
    ginit.ua   = a_ua;
    ginit.ub   = a_ub;
    ginit.bneg = a_bneg;
    ginit.k    = k0;
    ginit.u    = (x0 == '0) ? y0 : (x0 >> ctz(x0));
    ginit.v    = (x0 == '0) ? '0 : y0;
  end

  always_comb begin
    dinit.ua   = gs[NGCD].ua;
    dinit.ub   = gs[NGCD].ub;
    dinit.bneg = gs[NGCD].bneg;
    dinit.d    = gs[NGCD].u << gs[NGCD].k;
    dinit.ra   = '0;
    dinit.rb   = '0;
    dinit.qa   = '0;
    dinit.qb   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      gv <= '0;
      dv <= '0;
    end else begin
      av <= in_v && !same;
      gv <= {gv[NGCD-1:0], av};
      dv <= {dv[ROW_W-2:0], gv[NGCD]};
    end
  end

  always_ff @(posedge clk) begin
    a_ua   <= nr[ROW_W-1:0];
    a_ub   <= anc[ROW_W-1:0];
    a_bneg <= (nc < 0);
    gs[0]  <= ginit;
    for (int i = 1; i <= NGCD; i++) begin
      gs[i] <= gcd_step(gs[i-1]);
    end
    ds[0] <= div_step(dinit, ROW_W - 1);
    for (int i = 1; i < ROW_W; i++) begin
      ds[i] <= div_step(ds[i-1], ROW_W - 1 - i);
    end
  end

  always_comb begin
    bq    = {1'b0, ds[ROW_W-1].qb};
    b8    = ds[ROW_W-1].bneg ? -bq : bq;
    key   = {ds[ROW_W-1].qa, b8};
    out_v = dv[ROW_W-1];
    busy  = in_v | av | (|gv) | (|dv);
  end

endmodule

/* design/ctp_datapath.sv */
// ----------------------------------------------------------------------------
// ctp_datapath
// Point store, line fill counts, direction tally and running totals.
// ----------------------------------------------------------------------------
module ctp_datapath #(
  parameter int MAX_SIDE   = 128,
  parameter int MAX_POINTS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ctp_pkg::SIDE_W-1:0] cfg_wdata,
  input  ctp_pkg::req_t              req,
  input  ctp_pkg::cmd_t              cmd,
  output ctp_pkg::sts_t              sts,
  output ctp_pkg::rsp_t              rsp
);
  import ctp_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [SIDE_W-1:0] side;
  logic [SIDE_W:0]   side_eff;
  req_t              item;
  logic [CELL_W-1:0] spot;
  logic              is_add;

  logic              occ_mem [CELLS];
  logic [IW-1:0]     pos_mem [CELLS];
  logic [CELL_W-1:0] list_mem [MAX_POINTS];
  logic [FILL_W-1:0] row_mem [LINES];
  logic [FILL_W-1:0] col_mem [LINES];
  logic [LINES-1:0]  row_vld, col_vld;
  logic [KEY_W-1:0]  key_mem [MAX_POINTS];
  logic [CW-1:0]     cnt_mem [KEYS];

  logic              occ_q;
  logic [IW-1:0]     pos_q;
  logic [FILL_W-1:0] row_q, col_q, rf, cf, row_new, col_new;
  logic              rv_q, cv_q;
  logic [CELL_W-1:0] list_q;
  logic              list_rd;
  logic [IW-1:0]     list_raddr;
  logic [CW-1:0]     held, held_m1;
  logic [TOT_W-1:0]  total;
  logic [THRU_W-1:0] through;
  status_t           status, dec_status;
  logic              out_row, out_col;

  logic [CW-1:0]     scan_idx;
  logic              scan_more, scan_rd;
  logic              pv, pbusy;
  logic [KEY_W-1:0]  pkey;
  logic              s1_v, s1_fwd;
  logic [KEY_W-1:0]  s1_key;
  logic [CW-1:0]     fwd_val, cnt_q, s1_old, s1_new;
  logic [CW-1:0]     nk, clr_idx;
  logic              clr_more, clr_wr;
  logic [KEY_W-1:0]  kl_q;
  logic [KEY_W:0]    init_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SIDE_RESET;
    end else if (cfg_we) begin
      side <= cfg_wdata;
    end
  end

  always_comb begin
    if (side < SIDE_MIN) begin
      side_eff = {1'b0, SIDE_MIN};
    end else if ({1'b0, side} > (SIDE_W + 1)'(MAX_SIDE)) begin
      side_eff = (SIDE_W + 1)'(MAX_SIDE);
    end else begin
      side_eff = {1'b0, side};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= req;
  end

  assign spot   = {item.row, item.col};
  assign is_add = (item.kind == OP_ADD);

  // Lookups for the accepted cell
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      occ_q <= occ_mem[spot];
      pos_q <= pos_mem[spot];
      row_q <= row_mem[item.row];
      col_q <= col_mem[item.col];
      rv_q  <= row_vld[item.row];
      cv_q  <= col_vld[item.col];
    end
  end

  assign rf      = rv_q ? row_q : '0;
  assign cf      = cv_q ? col_q : '0;
  assign row_new = is_add ? rf + 1'b1 : ((rf != '0) ? rf - 1'b1 : '0);
  assign col_new = is_add ? cf + 1'b1 : ((cf != '0) ? cf - 1'b1 : '0);

  always_comb begin
    out_row = ((SIDE_W + 1)'(item.row) >= side_eff) || ((SIDE_W + 1)'(item.col) >= side_eff);
    out_col = ((SIDE_W + 1)'(item.row) >= (SIDE_W + 1)'(MAX_SIDE))
           || ((SIDE_W + 1)'(item.col) >= (SIDE_W + 1)'(MAX_SIDE));
    if (is_add) begin
      if (out_row) begin
        dec_status = ST_FULL;
      end else if (occ_q) begin
        dec_status = ST_OCCUPIED;
      end else if (rf >= LINE_CAP || cf >= LINE_CAP || held >= CW'(MAX_POINTS)) begin
        dec_status = ST_FULL;
      end else begin
        dec_status = ST_DONE;
      end
    end else begin
      if (out_col || !occ_q || held == '0) begin
        dec_status = ST_ABSENT;
      end else begin
        dec_status = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) status <= dec_status;
  end

  // Occupancy: swept to zero after reset
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      occ_mem[init_ctr[CELL_W-1:0]] <= 1'b0;
    end else if (cmd.fix_wr) begin
      occ_mem[spot] <= is_add;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_wr) begin
      if (is_add) begin
        pos_mem[spot] <= held[IW-1:0];
      end else begin
        pos_mem[list_q] <= pos_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      col_vld <= '0;
    end else if (cmd.fix_wr) begin
      row_vld[item.row] <= 1'b1;
      col_vld[item.col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_wr) begin
      row_mem[item.row] <= row_new;
      col_mem[item.col] <= col_new;
    end
  end

  // Point list: scan reads and the last-entry read of a removal share one port
  assign held_m1    = held - 1'b1;
  assign scan_more  = (scan_idx < held);
  assign list_rd    = (cmd.scan && scan_more) || cmd.fix_rd;
  assign list_raddr = cmd.fix_rd ? held_m1[IW-1:0] : scan_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fix_wr) begin
      if (is_add) begin
        list_mem[held[IW-1:0]] <= spot;
      end else begin
        list_mem[pos_q] <= list_q;
      end
    end
    if (list_rd) list_q <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      scan_rd  <= 1'b0;
    end else begin
      scan_rd <= cmd.scan && scan_more;
      if (cmd.latch) begin
        scan_idx <= '0;
      end else if (cmd.scan && scan_more) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  ctp_dir_pipe u_dir (
    .clk   (clk),
    .rst   (rst),
    .in_v  (scan_rd),
    .q     (list_q),
    .c     (spot),
    .out_v (pv),
    .key   (pkey),
    .busy  (pbusy)
  );

  // Tally stage: forward the previous write when it hits the same key
  assign s1_old = s1_fwd ? fwd_val : cnt_q;
  assign s1_new = s1_old + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= pv;
    end
  end

  always_ff @(posedge clk) begin
    s1_key  <= pkey;
    s1_fwd  <= s1_v && pv && (s1_key == pkey);
    fwd_val <= s1_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      cnt_mem[init_ctr[KEY_W-1:0]] <= '0;
    end else if (clr_wr) begin
      cnt_mem[kl_q] <= '0;
    end else if (s1_v) begin
      cnt_mem[s1_key] <= s1_new;
    end
    if (pv) cnt_q <= cnt_mem[pkey];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      through <= '0;
    end else if (s1_v) begin
      through <= through + THRU_W'(s1_old);
    end
  end

  assign clr_more = (clr_idx < nk);

  always_ff @(posedge clk) begin
    if (s1_v) key_mem[nk[IW-1:0]] <= s1_key;
    if (cmd.clear && clr_more) kl_q <= key_mem[clr_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nk      <= '0;
      clr_idx <= '0;
      clr_wr  <= 1'b0;
    end else begin
      clr_wr <= cmd.clear && clr_more;
      if (cmd.latch) begin
        nk      <= '0;
        clr_idx <= '0;
      end else begin
        if (s1_v) nk <= nk + 1'b1;
        if (cmd.clear && clr_more) clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_ctr <= '0;
    end else if (cmd.init_step && !init_ctr[KEY_W]) begin
      init_ctr <= init_ctr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      total <= '0;
    end else if (cmd.fix_wr) begin
      if (is_add) begin
        held  <= held + 1'b1;
        total <= total + TOT_W'(through);
      end else begin
        held  <= held_m1;
        total <= total - TOT_W'(through);
      end
    end
  end

  always_comb begin
    sts.init_done  = init_ctr[KEY_W];
    sts.refused    = (dec_status != ST_DONE);
    sts.scan_done  = !scan_more;
    sts.drain_done = !pbusy && !s1_v && !scan_rd;
    sts.clear_done = !clr_more && !clr_wr;
  end

  always_comb begin
    rsp.status          = status;
    rsp.triples_through = through;
    rsp.total_triples   = total;
    rsp.point_count     = PCNT_W'(held);
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_keys_bound: assert property (@(posedge clk) disable iff (rst)
    nk <= held)
    else $error("more directions tallied than points held");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.fix_wr && !is_add) |=> (held == $past(held) - 1'b1))
    else $error("removal did not drop the point count");

endmodule

/* design/ctp_ctrl.sv */
// ----------------------------------------------------------------------------
// ctp_ctrl
// Sequencer: post-reset sweep, lookup, scan, tally clear, store update and
// result handshake.
// ----------------------------------------------------------------------------
module ctp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  ctp_pkg::sts_t  sts,
  output ctp_pkg::cmd_t  cmd
);
  import ctp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   if (sts.init_done) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_LOOK;
      S_LOOK:   state_next = S_DECIDE;
      S_DECIDE: state_next = sts.refused ? S_RESP : S_SCAN;
      S_SCAN:   if (sts.scan_done) state_next = S_DRAIN;
      S_DRAIN:  if (sts.drain_done) state_next = S_CLEAR;
      S_CLEAR:  if (sts.clear_done) state_next = S_FIX_RD;
      S_FIX_RD: state_next = S_FIX_WR;
      S_FIX_WR: state_next = S_RESP;
      S_RESP:   if (!rsp_stall) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = (state != S_IDLE);
    rsp_valid = (state == S_RESP);
    case (state)
      S_INIT:   cmd.init_step = 1'b1;
      S_IDLE:   cmd.latch     = req_valid;
      S_LOOK:   cmd.look      = 1'b1;
      S_DECIDE: cmd.decide    = 1'b1;
      S_SCAN:   cmd.scan      = 1'b1;
      S_CLEAR:  cmd.clear     = 1'b1;
      S_FIX_RD: cmd.fix_rd    = 1'b1;
      S_FIX_WR: cmd.fix_wr    = 1'b1;
      default:  cmd           = '0;
    endcase
  end

endmodule

/* design/collinear_triple_point_set.sv */
// ----------------------------------------------------------------------------
// collinear_triple_point_set
// Point set on a square grid that counts collinear triples as cells come
// and go.
//
// Request channel (req_valid / req_stall / req) carries add or remove of one
// cell; the response channel (rsp_valid / rsp_stall / rsp) returns one
// transaction per request: status, triples through the cell, running total
// and point count. cfg_we / cfg_wdata write the grid side; write only while
// no request is in flight.
// A refused request goes from lookup and decision straight to the response. An
// accepted add or remove makes two passes before the store update:
// one pass over the point list through the direction pipeline (gcd and
// divide, 23 stages deep), then one pass clearing the direction tally
// memory. Each pass moves one point per cycle through the single tally port.
// One request is in flight at a time; the next is taken in the cycle after
// the response leaves.
// After reset req_stall stays high while the occupancy and tally memories are
// swept to zero. A stalled response holds until taken.
// ----------------------------------------------------------------------------
module collinear_triple_point_set #(
  parameter int MAX_SIDE   = 128,
  parameter int MAX_POINTS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ctp_pkg::SIDE_W-1:0] cfg_wdata,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  ctp_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ctp_pkg::rsp_t              rsp
);
  import ctp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ctp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctp_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

/* tb/collinear_triple_point_set_tb.sv */
// ----------------------------------------------------------------------------
// collinear_triple_point_set_tb
// Self-checking bench: drives add and remove transactions with random
// idling on both channels, predicts every response from its own copy of
// the point set and checks each field.
// ----------------------------------------------------------------------------
class triple_scoreboard;
  localparam int SIDE_LIM = 128;
  localparam int PT_LIM   = 256;

  bit               held [SIDE_LIM*SIDE_LIM];
  int               row_cnt [SIDE_LIM];
  int               col_cnt [SIDE_LIM];
  int               cells [$];
  int unsigned      tally;
  int unsigned      side_setting;
  ctp_pkg::rsp_t    pending [$];
  int               errors;
  int               checked;

  function void clear_set();
    foreach (held[i]) held[i] = 0;
    foreach (row_cnt[i]) begin
      row_cnt[i] = 0;
      col_cnt[i] = 0;
    end
    cells.delete();
    tally = 0;
    side_setting = 128;
    errors = 0;
    checked = 0;
  endfunction

  function int unsigned gcd_abs(int a, int b);
    int t;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // count pairs of other held cells sharing one normalised direction
  function int unsigned line_pairs(int spot);
    int keys [$];
    int a, b, g;
    int unsigned n;
    n = 0;
    foreach (cells[i]) begin
      if (cells[i] == spot) continue;
      a = cells[i] / SIDE_LIM - spot / SIDE_LIM;
      b = cells[i] % SIDE_LIM - spot % SIDE_LIM;
      g = gcd_abs(a, b);
      if (g == 0) continue;
      a /= g;
      b /= g;
      if (a < 0 || (a == 0 && b < 0)) begin
        a = -a;
        b = -b;
      end
      foreach (keys[k]) if (keys[k] == a * 1024 + b) n++;
      keys.push_back(a * 1024 + b);
    end
    return n;
  endfunction

  function void note_request(ctp_pkg::req_t r);
    ctp_pkg::rsp_t e;
    int unsigned side, thru;
    int spot, idx [$];
    side = side_setting < 2 ? 2 : (side_setting > SIDE_LIM ? SIDE_LIM : side_setting);
    spot = int'(r.row) * SIDE_LIM + int'(r.col);
    thru = 0;
    e.status = ctp_pkg::ST_DONE;
    if (r.kind == ctp_pkg::OP_ADD) begin
      if (r.row >= side || r.col >= side) e.status = ctp_pkg::ST_FULL;
      else if (held[spot]) e.status = ctp_pkg::ST_OCCUPIED;
      else if (row_cnt[r.row] >= 2 || col_cnt[r.col] >= 2 || cells.size() >= PT_LIM)
        e.status = ctp_pkg::ST_FULL;
      else begin
        thru = line_pairs(spot);
        tally += thru;
        held[spot] = 1;
        cells.push_back(spot);
        row_cnt[r.row]++;
        col_cnt[r.col]++;
      end
    end else begin
      if (!held[spot]) e.status = ctp_pkg::ST_ABSENT;
      else begin
        thru = line_pairs(spot);
        tally -= thru;
        idx = cells.find_first_index(x) with (x == spot);
        cells.delete(idx[0]);
        held[spot] = 0;
        row_cnt[r.row]--;
        col_cnt[r.col]--;
      end
    end
    e.triples_through = thru[14:0];
    e.total_triples = tally[21:0];
    e.point_count = 9'(cells.size());
    pending.push_back(e);
  endfunction

  function void check_response(ctp_pkg::rsp_t got);
    ctp_pkg::rsp_t e;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response %p", got);
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status || got.triples_through !== e.triples_through ||
        got.total_triples !== e.total_triples || got.point_count !== e.point_count) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
    end
  endfunction
endclass

module collinear_triple_point_set_tb;
  import ctp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [SIDE_W-1:0] cfg_wdata = '0;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  int hold_len = 0;
  bit hold_taken = 0;
  int unsigned side_now = 128;
  int unsigned fills = 0;
  triple_scoreboard board = new();

  collinear_triple_point_set dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_stall <= 1;
    end else if (hold_len > 0 && !hold_taken) begin
      hold_off <= hold_len;
      hold_taken <= 1;
      rsp_stall <= 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // valid stays up after acceptance until the next request or a quiet spell
  task automatic send(input kind_t k, input int r, input int c);
    req_t x;
    x.kind = k;
    x.row = r[6:0];
    x.col = c[6:0];
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= x;
    do @(posedge clk); while (req_stall);
    board.note_request(x);
  endtask

  task automatic write_side(input int unsigned s);
    req_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= s[7:0];
    @(posedge clk);
    cfg_we <= 0;
    board.side_setting = 32'(s[7:0]);
    side_now = s[7:0] < 8'd2 ? 2 : (s[7:0] > 8'd128 ? 128 : 32'(s[7:0]));
  endtask

  // mostly adds within the grid, removes of held cells, some noise
  task automatic random_op();
    int pick, c;
    pick = $urandom_range(99);
    if (pick < 55) send(OP_ADD, $urandom_range(side_now - 1), $urandom_range(side_now - 1));
    else if (pick < 85 && board.cells.size() > 0) begin
      c = board.cells[$urandom_range(board.cells.size() - 1)];
      send(OP_REMOVE, c / 128, c % 128);
    end else send(kind_t'($urandom_range(1)), $urandom_range(127), $urandom_range(127));
  endtask

  task automatic phase(input int n, input int si, input int rs, input int s);
    int r0;
    write_side(s);
    send_idle = si;
    recv_stall = rs;
    // clear what is left so each phase starts from an empty set
    while (board.cells.size() > 0) begin
      r0 = board.cells[0];
      send(OP_REMOVE, r0 / 128, r0 % 128);
    end
    repeat (n) random_op();
  endtask

  initial begin
    int i;
    board.clear_set();
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed: diagonal line, refusals, corners, remove of absent cell
    for (i = 0; i < 4; i++) send(OP_ADD, i, i);
    send(OP_ADD, 2, 2);
    send(OP_ADD, 0, 5);
    send(OP_ADD, 0, 9);
    send(OP_ADD, 127, 127);
    send(OP_ADD, 127, 0);
    send(OP_ADD, 0, 127);
    send(OP_REMOVE, 1, 1);
    send(OP_REMOVE, 1, 1);
    send(OP_REMOVE, 127, 127);
    send(OP_REMOVE, 3, 3);
    write_side(0);
    send(OP_ADD, 2, 0);
    send(OP_ADD, 1, 0);
    send(OP_REMOVE, 127, 0);
    write_side(255);
    send(OP_ADD, 127, 127);
    // long receiver hold-off while requests keep coming
    hold_len = 400;
    for (i = 0; i < 6; i++) send(OP_ADD, 10 + i, 20 + 2 * i);
    phase(300, 0, 0, 8);
    phase(300, 65, 0, 5);
    phase(300, 0, 65, 128);
    phase(300, 25, 25, 16);
    phase(200, 0, 0, 2);
    // fill the set to capacity on the full grid
    write_side(128);
    send_idle = 0;
    recv_stall = 0;
    for (i = 0; i < 128; i++) send(OP_ADD, i, (i * 37) % 128);
    for (i = 0; i < 130; i++) send(OP_ADD, i % 128, (i * 53 + 5) % 128);
    req_valid <= 0;
    fills = board.cells.size();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d responses over several grid sides; set reached %0d points",
             board.checked, fills);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS collinear_triple_point_set");
    end else begin
      $display("FAIL collinear_triple_point_set");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("FAIL collinear_triple_point_set");
    $finish;
  end
endmodule
